FILE: design/nrmc_pkg.sv
`default_nettype none

package nrmc_pkg;

    // Sentence header, first character in the top byte.
    localparam int          HDR_LEN  = 6;
    localparam logic [47:0] HDR_TEXT = "$GNRMC";

    localparam logic [7:0] CHAR_DOLLAR = "$";
    localparam logic [7:0] CHAR_STAR   = "*";
    localparam logic [7:0] CHAR_COMMA  = ",";
    localparam logic [7:0] CHAR_DOT    = ".";
    localparam logic [7:0] CHAR_ZERO   = "0";
    localparam logic [7:0] CHAR_NINE   = "9";

    localparam int          CODE_W    = 32;
    localparam int          SCALE_W   = 17;
    localparam int          PROD_W    = CODE_W + SCALE_W;
    localparam logic [SCALE_W-1:0] INT_SCALE = 17'd100000;
    localparam logic [CODE_W-1:0]  CODE_MAX  = 32'hFFFF_FFFF;

    // Comma counts that open the two position fields.
    localparam logic [2:0] FIELD_FIRST  = 3'd3;
    localparam logic [2:0] FIELD_SECOND = 3'd5;
    localparam logic [2:0] COMMA_MAX    = 3'd7;
    localparam logic [1:0] SEEN_BOTH    = 2'd2;
    localparam logic [1:0] SEEN_MAX     = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_H1,
        FS_H2,
        FS_H3,
        FS_H4,
        FS_H5,
        FS_BODY
    } front_state_t;

    typedef enum logic [2:0] {
        TOK_START,
        TOK_DIGIT,
        TOK_DOT,
        TOK_COMMA,
        TOK_STAR,
        TOK_OTHER
    } tok_kind_t;

    typedef enum logic [1:0] {
        PH_INT,
        PH_FRAC,
        PH_DONE
    } digit_phase_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

    // Write side of the token queue.
    typedef struct packed {
        logic   push;
        token_t tok;
    } q_wr_t;

    // Read side of the token queue.
    typedef struct packed {
        logic   avail;
        token_t tok;
    } q_rd_t;

    // Control carried along the field-close pipeline.
    typedef struct packed {
        logic start;
        logic star;
        logic wr_first;
        logic wr_second;
        logic both_seen;
    } close_ctl_t;

    function automatic logic [7:0] hdr_char(input int k);
        return HDR_TEXT[8*(HDR_LEN-1-k) +: 8];
    endfunction

    // acc * 10 + d, saturating at the 32-bit maximum.
    function automatic logic [CODE_W-1:0] sat_digit(input logic [CODE_W-1:0] acc,
                                                    input logic [3:0] d);
        logic [CODE_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{CODE_W{1'b0}}, d};
        return (v[CODE_W+3:CODE_W] != 4'd0) ? CODE_MAX : v[CODE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/nrmc_in_if.sv
`default_nettype none

interface nrmc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: design/nrmc_out_if.sv
`default_nettype none

interface nrmc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] latitude_code;
    logic [31:0] longitude_code;
    logic        valid_res;

    modport source (output valid, output latitude_code, output longitude_code,
                    output valid_res, input ready);
    modport sink   (input valid, input latitude_code, input longitude_code,
                    input valid_res, output ready);
endinterface

`default_nettype wire

FILE: design/nrmc_front.sv
`default_nettype none

// Header matcher and byte classifier. Sentence bytes become tokens.
module nrmc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    nrmc_in_if.sink             byte_ch,
    input  wire logic           q_full,
    output nrmc_pkg::q_wr_t     q_wr
);

    nrmc_pkg::front_state_t state_reg;
    nrmc_pkg::front_state_t state_next;

    logic       fire;
    logic [7:0] b;
    logic       is_digit;

    assign byte_ch.ready = !q_full;
    assign fire          = byte_ch.valid && !q_full;
    assign b             = byte_ch.in_byte;
    assign is_digit      = (b >= nrmc_pkg::CHAR_ZERO) && (b <= nrmc_pkg::CHAR_NINE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrmc_pkg::FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            if (b == nrmc_pkg::CHAR_DOLLAR)
            begin
                state_next = nrmc_pkg::FS_H1;
            end
            else
            begin
                case (state_reg)
                    nrmc_pkg::FS_H1:
                        state_next = (b == nrmc_pkg::hdr_char(1)) ? nrmc_pkg::FS_H2
                                                                   : nrmc_pkg::FS_IDLE;
                    nrmc_pkg::FS_H2:
                        state_next = (b == nrmc_pkg::hdr_char(2)) ? nrmc_pkg::FS_H3
                                                                   : nrmc_pkg::FS_IDLE;
                    nrmc_pkg::FS_H3:
                        state_next = (b == nrmc_pkg::hdr_char(3)) ? nrmc_pkg::FS_H4
                                                                   : nrmc_pkg::FS_IDLE;
                    nrmc_pkg::FS_H4:
                        state_next = (b == nrmc_pkg::hdr_char(4)) ? nrmc_pkg::FS_H5
                                                                   : nrmc_pkg::FS_IDLE;
                    nrmc_pkg::FS_H5:
                        state_next = (b == nrmc_pkg::hdr_char(5)) ? nrmc_pkg::FS_BODY
                                                                   : nrmc_pkg::FS_IDLE;
                    nrmc_pkg::FS_BODY:
                        state_next = (b == nrmc_pkg::CHAR_STAR) ? nrmc_pkg::FS_IDLE
                                                                 : nrmc_pkg::FS_BODY;
                    default:
                        state_next = nrmc_pkg::FS_IDLE;
                endcase
            end
        end
    end

    always_comb
    begin
        q_wr.push      = 1'b0;
        q_wr.tok.kind  = nrmc_pkg::TOK_OTHER;
        q_wr.tok.digit = b[3:0];
        if (fire && b != nrmc_pkg::CHAR_DOLLAR)
        begin
            case (state_reg)
                nrmc_pkg::FS_H5:
                begin
                    q_wr.push     = (b == nrmc_pkg::hdr_char(5));
                    q_wr.tok.kind = nrmc_pkg::TOK_START;
                end
                nrmc_pkg::FS_BODY:
                begin
                    q_wr.push = 1'b1;
                    if (is_digit)
                        q_wr.tok.kind = nrmc_pkg::TOK_DIGIT;
                    else if (b == nrmc_pkg::CHAR_DOT)
                        q_wr.tok.kind = nrmc_pkg::TOK_DOT;
                    else if (b == nrmc_pkg::CHAR_COMMA)
                        q_wr.tok.kind = nrmc_pkg::TOK_COMMA;
                    else if (b == nrmc_pkg::CHAR_STAR)
                        q_wr.tok.kind = nrmc_pkg::TOK_STAR;
                    else
                        q_wr.tok.kind = nrmc_pkg::TOK_OTHER;
                end
                default:
                begin
                    q_wr.push = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/nrmc_queue.sv
`default_nettype none

// Small token FIFO between the classifier and the field engine.
module nrmc_queue #(
    parameter int DEPTH = nrmc_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire nrmc_pkg::q_wr_t q_wr,
    input  wire logic           pop,
    output logic                full,
    output nrmc_pkg::q_rd_t     q_rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    nrmc_pkg::token_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign do_push    = q_wr.push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign q_rd.avail = (count_reg != '0);
    assign q_rd.tok   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= q_wr.tok;
    end

endmodule

`default_nettype wire

FILE: design/nrmc_back.sv
`default_nettype none

// Field engine: digit accumulation, field close pipeline and result register.
module nrmc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire nrmc_pkg::q_rd_t q_rd,
    output logic                pop,
    nrmc_out_if.source          result_ch
);

    localparam int CW = nrmc_pkg::CODE_W;
    localparam int PW = nrmc_pkg::PROD_W;

    logic [2:0]               comma_reg, comma_next;
    nrmc_pkg::digit_phase_t   phase_reg, phase_next;
    logic [CW-1:0]            int_reg, int_next;
    logic [CW-1:0]            frac_reg, frac_next;
    logic [1:0]               seen_reg, seen_next;

    logic                     s1_valid_reg, s1_valid_next;
    nrmc_pkg::close_ctl_t     s1_ctl_reg, s1_ctl_next;
    logic [CW-1:0]            s1_int_reg;
    logic [CW-1:0]            s1_frac_reg;

    logic                     s2_valid_reg;
    nrmc_pkg::close_ctl_t     s2_ctl_reg;
    logic [PW-1:0]            s2_prod_reg;
    logic [CW-1:0]            s2_frac_reg;

    logic [CW-1:0]            first_reg, second_reg;
    logic                     out_valid_reg;
    logic [CW-1:0]            lat_reg, lon_reg;
    logic                     vres_reg;

    logic                     adv;
    logic                     in_field;
    logic [PW:0]              code_sum;
    logic [CW-1:0]            code;
    logic [2:0]               comma_inc;

    assign adv      = !out_valid_reg || result_ch.ready;
    assign pop      = adv && q_rd.avail;
    assign in_field = (comma_reg == nrmc_pkg::FIELD_FIRST) ||
                      (comma_reg == nrmc_pkg::FIELD_SECOND);
    assign comma_inc = (comma_reg == nrmc_pkg::COMMA_MAX) ? comma_reg : comma_reg + 1'b1;

    // Token execution: parser state and the operands of a field close.
    always_comb
    begin
        comma_next    = comma_reg;
        phase_next    = phase_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;
        seen_next     = seen_reg;
        s1_valid_next = pop;
        s1_ctl_next   = '0;
        if (pop)
        begin
            case (q_rd.tok.kind)
                nrmc_pkg::TOK_START:
                begin
                    comma_next        = '0;
                    phase_next        = nrmc_pkg::PH_INT;
                    int_next          = '0;
                    frac_next         = '0;
                    seen_next         = '0;
                    s1_ctl_next.start = 1'b1;
                end
                nrmc_pkg::TOK_STAR:
                begin
                    s1_ctl_next.star      = 1'b1;
                    s1_ctl_next.wr_first  = (comma_reg == nrmc_pkg::FIELD_FIRST);
                    s1_ctl_next.wr_second = (comma_reg == nrmc_pkg::FIELD_SECOND);
                    s1_ctl_next.both_seen = (seen_reg == nrmc_pkg::SEEN_BOTH);
                end
                nrmc_pkg::TOK_COMMA:
                begin
                    s1_ctl_next.wr_first  = (comma_reg == nrmc_pkg::FIELD_FIRST);
                    s1_ctl_next.wr_second = (comma_reg == nrmc_pkg::FIELD_SECOND);
                    comma_next = comma_inc;
                    phase_next = nrmc_pkg::PH_INT;
                    int_next   = '0;
                    frac_next  = '0;
                    if ((comma_inc == nrmc_pkg::FIELD_FIRST ||
                         comma_inc == nrmc_pkg::FIELD_SECOND) &&
                        seen_reg != nrmc_pkg::SEEN_MAX)
                        seen_next = seen_reg + 1'b1;
                end
                nrmc_pkg::TOK_DIGIT:
                begin
                    if (in_field && phase_reg == nrmc_pkg::PH_INT)
                        int_next = nrmc_pkg::sat_digit(int_reg, q_rd.tok.digit);
                    else if (in_field && phase_reg == nrmc_pkg::PH_FRAC)
                        frac_next = nrmc_pkg::sat_digit(frac_reg, q_rd.tok.digit);
                end
                nrmc_pkg::TOK_DOT:
                begin
                    if (in_field && phase_reg == nrmc_pkg::PH_INT)
                        phase_next = nrmc_pkg::PH_FRAC;
                    else if (in_field)
                        phase_next = nrmc_pkg::PH_DONE;
                end
                default:
                begin
                    if (in_field)
                        phase_next = nrmc_pkg::PH_DONE;
                end
            endcase
        end
    end

    // Close stage: integer part times the scale plus fraction, saturating.
    assign code_sum = {1'b0, s2_prod_reg} + {{(PW+1-CW){1'b0}}, s2_frac_reg};
    assign code     = (code_sum[PW:CW] != '0) ? nrmc_pkg::CODE_MAX : code_sum[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comma_reg     <= '0;
            phase_reg     <= nrmc_pkg::PH_INT;
            int_reg       <= '0;
            frac_reg      <= '0;
            seen_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            comma_reg     <= comma_next;
            phase_reg     <= phase_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            seen_reg      <= seen_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_ctl_reg.star;
            if (s2_valid_reg && s2_ctl_reg.start)
            begin
                first_reg  <= '0;
                second_reg <= '0;
            end
            else if (s2_valid_reg && s2_ctl_reg.wr_first)
            begin
                first_reg <= code;
            end
            else if (s2_valid_reg && s2_ctl_reg.wr_second)
            begin
                second_reg <= code;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg  <= s1_ctl_next;
            s1_int_reg  <= int_reg;
            s1_frac_reg <= frac_reg;
            s2_ctl_reg  <= s1_ctl_reg;
            s2_prod_reg <= PW'(s1_int_reg) * PW'(nrmc_pkg::INT_SCALE);
            s2_frac_reg <= s1_frac_reg;
            if (s2_valid_reg && s2_ctl_reg.star)
            begin
                lat_reg  <= s2_ctl_reg.wr_first  ? code : first_reg;
                lon_reg  <= s2_ctl_reg.wr_second ? code : second_reg;
                vres_reg <= s2_ctl_reg.both_seen;
            end
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.latitude_code  = lat_reg;
    assign result_ch.longitude_code = lon_reg;
    assign result_ch.valid_res      = vres_reg;

endmodule

`default_nettype wire

FILE: design/nmea_rmc_position_extractor.sv
// NMEA RMC position extractor. Feed the receiver's serial stream one byte per
// transfer on byte_ch; the block takes one byte every clock cycle while its token
// queue is not full. It looks for the "$GNRMC" header, counts commas, and turns
// the fields after the third and fifth commas into codes of integer digits times
// 100000 plus the digits after the dot, saturating at 2^32-1. Each '*' inside a
// sentence yields one transfer on result_ch carrying both codes and valid_res,
// which is set when both fields were reached. A '$' restarts the header match
// and drops a sentence in progress without a result. A result is offered on
// result_ch once its '*' has passed the registered steps in order: taking the
// token out of the queue and capturing the field operands, forming the 32 by 17
// product, and adding the fraction, saturating and loading the result register.
// While a finished result waits for the sink the field engine holds still; the
// token queue between the classifier and the field engine, sized by QUEUE_DEPTH,
// takes up to QUEUE_DEPTH more sentence bytes meanwhile, and byte_ch.ready drops
// only when that queue is full.

`default_nettype none

module nmea_rmc_position_extractor #(
    parameter int QUEUE_DEPTH = nrmc_pkg::QUEUE_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nrmc_in_if.sink     byte_ch,
    nrmc_out_if.source  result_ch
);

    nrmc_pkg::q_wr_t q_wr;
    nrmc_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            q_pop;

    // Header match and byte classification.
    nrmc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_full  (q_full),
        .q_wr    (q_wr)
    );

    // Tokens wait here so that each side can stall on its own.
    nrmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    // Digit accumulation, field codes and the result register.
    nrmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .pop       (q_pop),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

FILE: design/nrmc_checker.sv
`default_nettype none

module nrmc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] lat,
    input wire logic [31:0] lon,
    input wire logic        vres
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(lat) && $stable(lon) && $stable(vres))
        else $error("result payload changed while stalled");

    // No result can be pending right after reset.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

    // With the sink ready the token queue drains, so the input is ready again in the next cycle.
    a_input_recovers: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(out_ready) && !$past(in_ready) |-> in_ready)
        else $error("input stalled although results were taken");

endmodule

bind nmea_rmc_position_extractor nrmc_checker u_nrmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .lat       (result_ch.latitude_code),
    .lon       (result_ch.longitude_code),
    .vres      (result_ch.valid_res)
);

`default_nettype wire
